@@ hw/rtl/pgh_pkg.sv @@
// Package for the patch gradient Hessian block: widths, defaults and the
// multiply sequence that forms the adjugate and the determinant.
// No dependencies.
`default_nettype none
package pgh_pkg;

    localparam int PATCH_WIDTH_DEF = 8;
    localparam int INV_FRAC_DEF    = 40;
    localparam int PIX_W           = 8;
    localparam int IDX_W           = 4;
    localparam int HESS_W          = 23;
    localparam int INV_W           = 64;
    localparam int NUM_ENTRIES     = 9;
    localparam int MUL_W           = 33;
    localparam int LO_W            = 32;
    localparam int NUM_STEPS       = 24;
    localparam int STEP_W          = 5;

    typedef enum logic [1:0] {
        BK_Q,
        BK_ADJ_LO,
        BK_ADJ_HI
    } bkind_t;

    typedef struct packed {
        logic [IDX_W-1:0] a_idx;
        logic [IDX_W-1:0] b_idx;
        bkind_t           b_kind;
        logic             neg;
        logic             load;
        logic             st_adj;
        logic             st_det;
        logic [IDX_W-1:0] dst_idx;
    } step_t;

    function automatic step_t mk(input int a, input int b, input bkind_t k,
                                 input logic n, input logic l, input logic sa,
                                 input logic sd, input int d);
        step_t r;
        r.a_idx   = IDX_W'(a);
        r.b_idx   = IDX_W'(b);
        r.b_kind  = k;
        r.neg     = n;
        r.load    = l;
        r.st_adj  = sa;
        r.st_det  = sd;
        r.dst_idx = IDX_W'(d);
        return r;
    endfunction

    // Each adjugate entry takes two products; the determinant expands along row zero.
    function automatic step_t step_rom(input logic [STEP_W-1:0] s);
        step_t r;
        case (s)
            5'd0:    r = mk(4, 8, BK_Q, 1'b0, 1'b1, 1'b0, 1'b0, 0);
            5'd1:    r = mk(5, 7, BK_Q, 1'b1, 1'b0, 1'b1, 1'b0, 0);
            5'd2:    r = mk(3, 8, BK_Q, 1'b1, 1'b1, 1'b0, 1'b0, 1);
            5'd3:    r = mk(5, 6, BK_Q, 1'b0, 1'b0, 1'b1, 1'b0, 1);
            5'd4:    r = mk(3, 7, BK_Q, 1'b0, 1'b1, 1'b0, 1'b0, 2);
            5'd5:    r = mk(4, 6, BK_Q, 1'b1, 1'b0, 1'b1, 1'b0, 2);
            5'd6:    r = mk(1, 8, BK_Q, 1'b1, 1'b1, 1'b0, 1'b0, 3);
            5'd7:    r = mk(2, 7, BK_Q, 1'b0, 1'b0, 1'b1, 1'b0, 3);
            5'd8:    r = mk(0, 8, BK_Q, 1'b0, 1'b1, 1'b0, 1'b0, 4);
            5'd9:    r = mk(2, 6, BK_Q, 1'b1, 1'b0, 1'b1, 1'b0, 4);
            5'd10:   r = mk(0, 7, BK_Q, 1'b1, 1'b1, 1'b0, 1'b0, 5);
            5'd11:   r = mk(1, 6, BK_Q, 1'b0, 1'b0, 1'b1, 1'b0, 5);
            5'd12:   r = mk(1, 5, BK_Q, 1'b0, 1'b1, 1'b0, 1'b0, 6);
            5'd13:   r = mk(2, 4, BK_Q, 1'b1, 1'b0, 1'b1, 1'b0, 6);
            5'd14:   r = mk(0, 5, BK_Q, 1'b1, 1'b1, 1'b0, 1'b0, 7);
            5'd15:   r = mk(2, 3, BK_Q, 1'b0, 1'b0, 1'b1, 1'b0, 7);
            5'd16:   r = mk(0, 4, BK_Q, 1'b0, 1'b1, 1'b0, 1'b0, 8);
            5'd17:   r = mk(1, 3, BK_Q, 1'b1, 1'b0, 1'b1, 1'b0, 8);
            5'd18:   r = mk(0, 0, BK_ADJ_LO, 1'b0, 1'b1, 1'b0, 1'b0, 0);
            5'd19:   r = mk(0, 0, BK_ADJ_HI, 1'b0, 1'b0, 1'b0, 1'b0, 0);
            5'd20:   r = mk(1, 1, BK_ADJ_LO, 1'b0, 1'b0, 1'b0, 1'b0, 0);
            5'd21:   r = mk(1, 1, BK_ADJ_HI, 1'b0, 1'b0, 1'b0, 1'b0, 0);
            5'd22:   r = mk(2, 2, BK_ADJ_LO, 1'b0, 1'b0, 1'b0, 1'b0, 0);
            5'd23:   r = mk(2, 2, BK_ADJ_HI, 1'b0, 1'b0, 1'b0, 1'b1, 0);
            default: r = mk(0, 0, BK_Q, 1'b0, 1'b0, 1'b0, 1'b0, 0);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/patch_gradient_hessian_inverse_top.sv @@
// Top level of the patch gradient Hessian block: pixel chain, sums, multiply
// sequencer and divider. Depends on pgh_pkg, pgh_cell and pgh_div.
//
// Usage: a pixel beat is taken at a rising edge where start is high and busy
// is low. A patch is (PATCH_WIDTH+2)^2 pixels of a bordered patch in raster
// order, one per cycle at most. The pixels pass through a chain of
// 2*(PATCH_WIDTH+2) pixel cells whose taps give the left, right and upper
// neighbors; gradient products are summed in the cycle after each interior beat.
// After the last pixel busy rises: the multiply sequencer uses one shared
// 33x33 multiplier for 24 products (adjugate and determinant), then one
// bit-serial divider forms each inverse entry in turn; the sums are QW bits
// wide (25 at the default size). Each of the nine results is shown on the
// result ports for one cycle with result_strobe high; results cannot be held
// off. A singular matrix skips the divider and gives the nine results on
// consecutive cycles. busy falls in the cycle after the last result. Reset
// clears the sums, the position, the chain and the sequencer; the block then
// takes pixels.
`default_nettype none
module patch_gradient_hessian_inverse_top #(
    parameter int PATCH_WIDTH           = pgh_pkg::PATCH_WIDTH_DEF,
    parameter int INVERSE_FRACTION_BITS = pgh_pkg::INV_FRAC_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic        [pgh_pkg::PIX_W-1:0]   pixel,
    output logic                                    result_strobe,
    output logic             [pgh_pkg::IDX_W-1:0]   entry_index,
    output logic signed      [pgh_pkg::HESS_W-1:0]  hessian_value,
    output logic signed      [pgh_pkg::INV_W-1:0]   inverse_value,
    output logic                                    singular,
    output logic                                    last_entry
);
    import pgh_pkg::*;

    localparam int SIDE  = PATCH_WIDTH + 2;
    localparam int CHAIN = 2 * SIDE;
    localparam int POS_W = $clog2(SIDE);
    localparam int CW    = $clog2(PATCH_WIDTH * PATCH_WIDTH + 1);
    localparam int QW    = 18 + CW;
    localparam int AW    = 2 * QW + 1;
    localparam int DW    = 3 * QW + 3;
    localparam int PW    = 2 * MUL_W;

    typedef enum logic [3:0] {
        S_STREAM,
        S_FLUSH,
        S_MUL,
        S_DRAIN,
        S_CHECK,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT,
        S_CLEAR
    } state_t;

    state_t                 state_reg;
    logic [POS_W-1:0]       row_reg;
    logic [POS_W-1:0]       col_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [IDX_W-1:0]       entry_reg;
    logic                   strobe_reg;
    logic [IDX_W-1:0]       eidx_reg;
    logic [HESS_W-1:0]      hess_reg;
    logic [INV_W-1:0]       inv_reg;
    logic                   sing_reg;
    logic                   last_reg;

    logic                   gd_vld_reg;
    logic signed [PIX_W:0]  dx_reg;
    logic signed [PIX_W:0]  dy_reg;
    logic signed [QW-1:0]   sxx_reg;
    logic signed [QW-1:0]   sxy_reg;
    logic signed [QW-1:0]   syy_reg;
    logic signed [QW-1:0]   sx_reg;
    logic signed [QW-1:0]   sy_reg;

    logic signed [PW-1:0]   prod_reg;
    step_t                  ctl_reg;
    logic                   ctl_vld_reg;
    logic signed [DW-1:0]   acc_reg;
    logic signed [DW-1:0]   det_reg;
    logic signed [AW-1:0]   adj_reg [NUM_ENTRIES];

    logic                   accept;
    logic                   interior;
    logic                   last_px;
    logic [PIX_W-1:0]       tap [CHAIN];
    logic signed [QW-1:0]   q_vec [NUM_ENTRIES];
    step_t                  cur_step;
    logic [IDX_W-1:0]       adj_idx;
    logic signed [AW-1:0]   adj_rd;
    logic signed [MUL_W-1:0] a_op;
    logic signed [MUL_W-1:0] b_op;
    logic signed [DW-1:0]   p_ext;
    logic signed [DW-1:0]   p_sh;
    logic signed [DW-1:0]   term;
    logic signed [DW-1:0]   acc_next;
    logic                   div_start;
    logic                   div_done;
    logic [INV_W-1:0]       div_quot;

    assign busy     = state_reg != S_STREAM;
    assign accept   = start && !busy;
    assign interior = row_reg >= POS_W'(2) && col_reg >= POS_W'(1)
                      && col_reg <= POS_W'(PATCH_WIDTH);
    assign last_px  = row_reg == POS_W'(SIDE - 1) && col_reg == POS_W'(SIDE - 1);

    genvar gi;
    generate
        for (gi = 0; gi < CHAIN; gi++)
        begin : g_chain
            pgh_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (accept),
                .d     ((gi == 0) ? pixel : tap[(gi == 0) ? 0 : gi - 1]),
                .q     (tap[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gd_vld_reg <= 1'b0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            sxx_reg    <= '0;
            sxy_reg    <= '0;
            syy_reg    <= '0;
            sx_reg     <= '0;
            sy_reg     <= '0;
        end
        else
        begin
            gd_vld_reg <= accept && interior;
            if (accept)
            begin
                dx_reg <= $signed({1'b0, tap[SIDE-2]}) - $signed({1'b0, tap[SIDE]});
                dy_reg <= $signed({1'b0, pixel}) - $signed({1'b0, tap[CHAIN-1]});
                if (col_reg == POS_W'(SIDE - 1))
                begin
                    col_reg <= '0;
                    row_reg <= last_px ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (state_reg == S_CLEAR)
            begin
                sxx_reg <= '0;
                sxy_reg <= '0;
                syy_reg <= '0;
                sx_reg  <= '0;
                sy_reg  <= '0;
            end
            else if (gd_vld_reg)
            begin
                sxx_reg <= sxx_reg + QW'(dx_reg) * QW'(dx_reg);
                sxy_reg <= sxy_reg + QW'(dx_reg) * QW'(dy_reg);
                syy_reg <= syy_reg + QW'(dy_reg) * QW'(dy_reg);
                sx_reg  <= sx_reg + QW'(dx_reg);
                sy_reg  <= sy_reg + QW'(dy_reg);
            end
        end
    end

    always_comb
    begin
        q_vec[0] = sxx_reg;
        q_vec[1] = sxy_reg;
        q_vec[2] = sx_reg <<< 1;
        q_vec[3] = sxy_reg;
        q_vec[4] = syy_reg;
        q_vec[5] = sy_reg <<< 1;
        q_vec[6] = sx_reg <<< 1;
        q_vec[7] = sy_reg <<< 1;
        q_vec[8] = QW'(4 * PATCH_WIDTH * PATCH_WIDTH);
    end

    assign cur_step = step_rom(step_reg);
    assign adj_idx  = (state_reg == S_MUL) ? cur_step.b_idx : entry_reg;
    assign adj_rd   = adj_reg[adj_idx];
    assign a_op     = MUL_W'(q_vec[cur_step.a_idx]);

    always_comb
    begin
        case (cur_step.b_kind)
            BK_Q:      b_op = MUL_W'(q_vec[cur_step.b_idx]);
            BK_ADJ_LO: b_op = $signed({1'b0, adj_rd[LO_W-1:0]});
            BK_ADJ_HI: b_op = MUL_W'($signed(adj_rd[AW-1:LO_W]));
            default:   b_op = '0;
        endcase
    end

    assign p_ext    = DW'(prod_reg);
    assign p_sh     = (ctl_reg.b_kind == BK_ADJ_HI) ? (p_ext <<< LO_W) : p_ext;
    assign term     = ctl_reg.neg ? -p_sh : p_sh;
    assign acc_next = ctl_reg.load ? term : acc_reg + term;

    always_ff @(posedge clk)
    begin
        prod_reg <= a_op * b_op;
        ctl_reg  <= cur_step;
        if (ctl_vld_reg)
        begin
            acc_reg <= acc_next;
            if (ctl_reg.st_adj)
            begin
                adj_reg[ctl_reg.dst_idx] <= AW'(acc_next);
            end
            if (ctl_reg.st_det)
            begin
                det_reg <= acc_next;
            end
        end
    end

    assign div_start = state_reg == S_DIV_GO;

    pgh_div #(
        .AW (AW),
        .DW (DW),
        .FB (INVERSE_FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .cof   (adj_rd),
        .det   (det_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_STREAM;
            step_reg    <= '0;
            entry_reg   <= '0;
            ctl_vld_reg <= 1'b0;
            strobe_reg  <= 1'b0;
            eidx_reg    <= '0;
            hess_reg    <= '0;
            inv_reg     <= '0;
            sing_reg    <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg  <= 1'b0;
            ctl_vld_reg <= state_reg == S_MUL;
            case (state_reg)
                S_STREAM:
                begin
                    if (accept && last_px)
                    begin
                        state_reg <= S_FLUSH;
                    end
                end
                S_FLUSH:
                begin
                    step_reg  <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(NUM_STEPS - 1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    entry_reg <= '0;
                    sing_reg  <= det_reg == '0;
                    state_reg <= (det_reg == '0) ? S_EMIT : S_DIV_GO;
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT, S_EMIT:
                begin
                    if (div_done || state_reg == S_EMIT)
                    begin
                        strobe_reg <= 1'b1;
                        eidx_reg   <= entry_reg;
                        hess_reg   <= HESS_W'(q_vec[entry_reg]);
                        inv_reg    <= (state_reg == S_EMIT) ? '0 : div_quot;
                        last_reg   <= entry_reg == IDX_W'(NUM_ENTRIES - 1);
                        entry_reg  <= entry_reg + 1'b1;
                        if (entry_reg == IDX_W'(NUM_ENTRIES - 1))
                        begin
                            state_reg <= S_CLEAR;
                        end
                        else if (state_reg == S_DIV_WAIT)
                        begin
                            state_reg <= S_DIV_GO;
                        end
                    end
                end
                S_CLEAR:
                begin
                    state_reg <= S_STREAM;
                end
                default:
                begin
                    state_reg <= S_STREAM;
                end
            endcase
        end
    end

    assign result_strobe = strobe_reg;
    assign entry_index   = eidx_reg;
    assign hessian_value = hess_reg;
    assign inverse_value = inv_reg;
    assign singular      = sing_reg;
    assign last_entry    = last_reg;
endmodule
`default_nettype wire

@@ hw/rtl/pgh_cell.sv @@
// One pixel cell of the row delay chain: holds one pixel and hands it on.
// Depends on pgh_pkg.
`default_nettype none
module pgh_cell (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     shift,
    input  wire logic [pgh_pkg::PIX_W-1:0] d,
    output logic      [pgh_pkg::PIX_W-1:0] q
);
    import pgh_pkg::*;

    logic [PIX_W-1:0] pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg <= '0;
        end
        else if (shift)
        begin
            pix_reg <= d;
        end
    end

    assign q = pix_reg;
endmodule
`default_nettype wire

@@ hw/rtl/pgh_div.sv @@
// Bit-serial restoring divider giving a rounded, saturated fixed-point quotient.
// Depends on pgh_pkg.
`default_nettype none
module pgh_div #(
    parameter int AW = 51,
    parameter int DW = 78,
    parameter int FB = pgh_pkg::INV_FRAC_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [AW-1:0]     cof,
    input  wire logic signed [DW-1:0]     det,
    output logic                          done,
    output logic [pgh_pkg::INV_W-1:0]     quot
);
    import pgh_pkg::*;

    localparam int NW    = AW + FB + 2;
    localparam int CNT_W = $clog2(NW + 1);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_ROUND
    } dstate_t;

    dstate_t          state_reg;
    logic [NW-1:0]    num_reg;
    logic [DW-1:0]    dmag_reg;
    logic [DW-1:0]    rem_reg;
    logic [INV_W-1:0] q_reg;
    logic             ovf_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [INV_W-1:0] quot_reg;

    logic [AW-1:0]    cof_mag;
    logic [DW-1:0]    det_mag;
    logic [DW:0]      r2;
    logic             fits;
    logic [DW+1:0]    rr;
    logic             up;
    logic [INV_W:0]   q65;

    assign cof_mag = cof[AW-1] ? AW'(-cof) : AW'(cof);
    assign det_mag = det[DW-1] ? DW'(-det) : DW'(det);
    assign r2      = {rem_reg, num_reg[NW-1]};
    assign fits    = r2 >= {1'b0, dmag_reg};
    assign rr      = {1'b0, rem_reg, 1'b0};
    assign up      = rr >= {2'b00, dmag_reg};
    assign q65     = {1'b0, q_reg} + (INV_W + 1)'(up);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            num_reg   <= '0;
            dmag_reg  <= '0;
            rem_reg   <= '0;
            q_reg     <= '0;
            ovf_reg   <= 1'b0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            quot_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        num_reg   <= {cof_mag, {(FB + 2){1'b0}}};
                        dmag_reg  <= det_mag;
                        neg_reg   <= cof[AW-1] ^ det[DW-1];
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        ovf_reg   <= 1'b0;
                        cnt_reg   <= CNT_W'(NW);
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    rem_reg <= fits ? DW'(r2 - {1'b0, dmag_reg}) : DW'(r2);
                    q_reg   <= {q_reg[INV_W-2:0], fits};
                    ovf_reg <= ovf_reg | q_reg[INV_W-1];
                    num_reg <= {num_reg[NW-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= D_ROUND;
                    end
                end
                D_ROUND:
                begin
                    if (!neg_reg)
                    begin
                        if (ovf_reg || q65 > {2'b00, {(INV_W - 1){1'b1}}})
                        begin
                            quot_reg <= {1'b0, {(INV_W - 1){1'b1}}};
                        end
                        else
                        begin
                            quot_reg <= q65[INV_W-1:0];
                        end
                    end
                    else
                    begin
                        if (ovf_reg || q65 > {2'b01, {(INV_W - 1){1'b0}}})
                        begin
                            quot_reg <= {1'b1, {(INV_W - 1){1'b0}}};
                        end
                        else
                        begin
                            quot_reg <= INV_W'(-q65[INV_W-1:0]);
                        end
                    end
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule
`default_nettype wire

@@ hw/rtl/pgh_checker.sv @@
// Port-level checks for the patch gradient Hessian block, bound to its top.
// Depends on pgh_pkg and patch_gradient_hessian_inverse_top.
`default_nettype none
module pgh_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               busy,
    input wire logic                               result_strobe,
    input wire logic        [pgh_pkg::IDX_W-1:0]   entry_index,
    input wire logic signed [pgh_pkg::INV_W-1:0]   inverse_value,
    input wire logic                               singular,
    input wire logic                               last_entry
);
    import pgh_pkg::*;

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result beat outside the busy window");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (last_entry == (entry_index == IDX_W'(NUM_ENTRIES - 1))))
        else $error("last_entry does not match the ninth entry");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && singular |-> inverse_value == '0)
        else $error("singular beat with a nonzero inverse");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && last_entry |=> !result_strobe)
        else $error("result beat after the last entry");

    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(result_strobe && last_entry))
        else $error("busy fell without a last result beat");
endmodule

bind patch_gradient_hessian_inverse_top pgh_checker u_pgh_checker (.*);
`default_nettype wire

@@ dv/patch_gradient_hessian_inverse_top_test.sv @@
// Testbench for patch_gradient_hessian_inverse_top: streams bordered patches,
// predicts the Hessian and its fixed-point inverse, checks every result.
// Depends on pgh_pkg and the block's RTL.
`default_nettype none
module patch_gradient_hessian_inverse_top_test;
    import pgh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW = PATCH_WIDTH_DEF;
    localparam int FB = INV_FRAC_DEF;
    localparam int SIDE = PW + 2;
    localparam int PATCH_PIXELS = SIDE * SIDE;
    localparam int WATCHDOG_LIMIT = 6000;

    typedef struct {
        logic [IDX_W-1:0]         idx;
        logic signed [HESS_W-1:0] hess;
        logic signed [INV_W-1:0]  inv;
        logic                     sing;
        logic                     last;
    } hess_result_t;

    class hessian_scoreboard;
        hess_result_t pending[$];
        int           errors;
        logic [7:0]   row_above[SIDE];
        logic [7:0]   row_cur[SIDE];
        longint       s_xx, s_xy, s_yy, s_x, s_y;
        int           position;
        logic [7:0]   held_left;

        function new();
            errors = 0;
            position = 0;
            held_left = 0;
            s_xx = 0; s_xy = 0; s_yy = 0; s_x = 0; s_y = 0;
            foreach (row_above[i])
            begin
                row_above[i] = 0;
                row_cur[i] = 0;
            end
        endfunction

        function logic signed [INV_W-1:0] fixed_inverse(longint cof,
                                                         logic signed [127:0] det);
            logic               neg;
            logic [127:0]       dmag, num, quo, rem;
            neg = (cof < 0) ^ det[127];
            dmag = det[127] ? -det : det;
            num = (cof < 0) ? 128'(-cof) : 128'(cof);
            num = num << (FB + 2);
            quo = num / dmag;
            rem = num % dmag;
            if ((rem << 1) >= dmag)
                quo = quo + 1;
            if (!neg)
                return (quo > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : quo[63:0];
            if (quo > 128'h8000_0000_0000_0000)
                return 64'h8000_0000_0000_0000;
            return -quo[63:0];
        endfunction

        function void note_pixel(logic [7:0] px);
            int                  row, col;
            longint              dx, dy;
            longint              q[9], adj[9];
            logic signed [127:0] det;
            hess_result_t        r;
            row = position / SIDE;
            col = position % SIDE;
            if (row >= 2 && col >= 1 && col <= PW)
            begin
                dy = longint'(px) - longint'(row_above[col]);
                dx = longint'(row_cur[col + 1]) - longint'(held_left);
                s_xx += dx * dx;
                s_xy += dx * dy;
                s_yy += dy * dy;
                s_x += dx;
                s_y += dy;
            end
            held_left = row_cur[col];
            row_above[col] = row_cur[col];
            row_cur[col] = px;
            position++;
            if (position < PATCH_PIXELS)
                return;
            q[0] = s_xx; q[1] = s_xy; q[2] = 2 * s_x;
            q[3] = q[1]; q[4] = s_yy; q[5] = 2 * s_y;
            q[6] = q[2]; q[7] = q[5]; q[8] = 4 * PW * PW;
            adj[0] = q[4] * q[8] - q[5] * q[7];
            adj[1] = -(q[3] * q[8] - q[5] * q[6]);
            adj[2] = q[3] * q[7] - q[4] * q[6];
            adj[3] = -(q[1] * q[8] - q[2] * q[7]);
            adj[4] = q[0] * q[8] - q[2] * q[6];
            adj[5] = -(q[0] * q[7] - q[1] * q[6]);
            adj[6] = q[1] * q[5] - q[2] * q[4];
            adj[7] = -(q[0] * q[5] - q[2] * q[3]);
            adj[8] = q[0] * q[4] - q[1] * q[3];
            det = 128'(q[0]) * 128'(adj[0]) + 128'(q[1]) * 128'(adj[1])
                + 128'(q[2]) * 128'(adj[2]);
            for (int k = 0; k < 9; k++)
            begin
                r.idx = IDX_W'(k);
                r.hess = q[k][HESS_W-1:0];
                r.sing = (det == 0);
                r.inv = r.sing ? '0 : fixed_inverse(adj[k], det);
                r.last = (k == 8);
                pending.push_back(r);
            end
            s_xx = 0; s_xy = 0; s_yy = 0; s_x = 0; s_y = 0;
            position = 0;
        endfunction

        function void check_result(hess_result_t got);
            hess_result_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result, entry_index %0d", got.idx);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.idx !== want.idx)
            begin
                $error("entry_index expected %0d actual %0d", want.idx, got.idx);
                errors++;
            end
            if (got.hess !== want.hess)
            begin
                $error("hessian_value expected %0d actual %0d", want.hess, got.hess);
                errors++;
            end
            if (got.inv !== want.inv)
            begin
                $error("inverse_value expected %0d actual %0d", want.inv, got.inv);
                errors++;
            end
            if (got.sing !== want.sing)
            begin
                $error("singular expected %0b actual %0b", want.sing, got.sing);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last_entry expected %0b actual %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [PIX_W-1:0]         pixel;
    logic                     result_strobe;
    logic [IDX_W-1:0]         entry_index;
    logic signed [HESS_W-1:0] hessian_value;
    logic signed [INV_W-1:0]  inverse_value;
    logic                     singular;
    logic                     last_entry;

    hessian_scoreboard sb;
    int                beats_taken;
    int                quiet_cycles;
    int                idle_pct;
    logic [7:0]        patch_buf[PATCH_PIXELS];

    patch_gradient_hessian_inverse_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .pixel(pixel),
        .result_strobe(result_strobe),
        .entry_index(entry_index),
        .hessian_value(hessian_value),
        .inverse_value(inverse_value),
        .singular(singular),
        .last_entry(last_entry)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        hess_result_t got;
        logic         moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (start && !busy)
            begin
                sb.note_pixel(pixel);
                beats_taken <= beats_taken + 1;
                moved = 1'b1;
            end
            if (result_strobe)
            begin
                got.idx = entry_index;
                got.hess = hessian_value;
                got.inv = inverse_value;
                got.sing = singular;
                got.last = last_entry;
                sb.check_result(got);
                moved = 1'b1;
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_pixel(input logic [7:0] v);
        int seen;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        seen = beats_taken;
        start <= 1'b1;
        pixel <= v;
        do
            @(negedge clk);
        while (beats_taken == seen);
    endtask

    task automatic send_patch();
        for (int i = 0; i < PATCH_PIXELS; i++)
            send_pixel(patch_buf[i]);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int base, mode;
        sb = new();
        beats_taken = 0;
        quiet_cycles = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        pixel = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (patch_buf[i])
            patch_buf[i] = 8'd0;
        send_patch();
        foreach (patch_buf[i])
            patch_buf[i] = ((i % SIDE) < SIDE / 2) ? 8'd0 : 8'd255;
        send_patch();
        wait_drained();

        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0: idle_pct = 0;
                1: idle_pct = 56;
                default: idle_pct = 34;
            endcase
            mode = (p == 0) ? 0 : $urandom_range(2);
            base = $urandom_range(255);
            foreach (patch_buf[i])
            begin
                if (mode == 0)
                    patch_buf[i] = 8'($urandom_range(255));
                else if (mode == 1)
                    patch_buf[i] = 8'(base + $urandom_range(6));
                else
                    patch_buf[i] = 8'(base + (i % SIDE) * $urandom_range(3)
                                      + (i / SIDE) * 2);
            end
            send_patch();
            if (p == 1)
                wait_drained();
        end
        wait_drained();
        repeat (50) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

@@ patch_gradient_hessian_inverse_top.f @@
hw/rtl/pgh_pkg.sv
hw/rtl/pgh_cell.sv
hw/rtl/pgh_div.sv
hw/rtl/patch_gradient_hessian_inverse_top.sv
hw/rtl/pgh_checker.sv
dv/patch_gradient_hessian_inverse_top_test.sv
